[hw/rtl/mme_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the matrix multiply engine.
// No dependencies; used by matrix_multiply_engine_unit.
package mme_pkg;

  // Input command codes
  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // Configuration register indexes (byte address 4*index)
  localparam logic [1:0] REG_A_ROWS    = 2'd0;
  localparam logic [1:0] REG_INNER     = 2'd1;
  localparam logic [1:0] REG_B_COLS    = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int DIM_W      = 4;
  localparam int THR_W      = 16;

  // Matrix side limit; tied to the 3-bit row/col fields and DIM_W
  localparam int MAX_DIM    = 8;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

endpackage

[hw/rtl/matrix_multiply_engine_unit.sv]
`timescale 1ns / 1ps
// Matrix multiply engine: element stores for A and B, one shared
// multiply-accumulate unit under a sequencer, APB-style config registers.
// Depends on mme_pkg.
//
// Load commands (A or B element) are taken while idle and give no result.
// A compute command holds the input stalled while the product is formed:
// every product element takes one store read step, one multiply step and
// one accumulate step per inner term, plus a final step to saturate, flush
// and hand it to the output register; that step waits while the output
// register is full and stalled. The single 32x32 multiplier and the 64-bit
// saturating accumulator serve every term in turn. The output register lets
// the next element be formed while the previous one waits to be taken.
// Stores are not cleared after reset; read only elements that were loaded.
module matrix_multiply_engine_unit
  import mme_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]         state_r, state_nxt;

  // Configuration registers
  logic [DIM_W-1:0]   a_rows_r;
  logic [DIM_W-1:0]   inner_r;
  logic [DIM_W-1:0]   b_cols_r;
  logic [THR_W-1:0]   thr_r;
  logic               cfg_we;

  // Dimensions latched at compute start
  logic [DIM_W-1:0]   rows_r, rows_nxt;
  logic [DIM_W-1:0]   inn_r, inn_nxt;
  logic [DIM_W-1:0]   cols_r, cols_nxt;
  logic [THR_W-1:0]   run_thr_r;

  // Loop counters
  logic [DIM_W-1:0]   i_r, i_nxt;
  logic [DIM_W-1:0]   j_r, j_nxt;
  logic [DIM_W-1:0]   k_r, k_nxt;

  // Stores and datapath
  logic [31:0]        a_mem [DEPTH];
  logic [31:0]        b_mem [DEPTH];
  logic [31:0]        a_rd_r;
  logic [31:0]        b_rd_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r, acc_nxt;

  logic               in_xfer;
  logic               ld_in_range;
  logic               a_we, b_we;
  logic [IDX_W-1:0]   ld_addr;
  logic [IDX_W-1:0]   a_rd_addr;
  logic [IDX_W-1:0]   b_rd_addr;

  logic signed [63:0] term;
  logic signed [64:0] sum_ext;
  logic signed [63:0] acc_sat;
  logic               hi_ok;
  logic signed [31:0] res_sat;
  logic [32:0]        res_mag;
  logic signed [31:0] res_final;
  logic               out_free;
  logic               emit;
  logic               last_elem;
  logic               last_term;

  out_item_t          out_r;
  logic               out_valid_r, out_valid_nxt;

  // Clamp a dimension register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  // Config port: always ready, write on access phase
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_W'(1);
      inner_r  <= DIM_W'(1);
      b_cols_r <= DIM_W'(1);
      thr_r    <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_A_ROWS:    a_rows_r <= pwdata[DIM_W-1:0];
        REG_INNER:     inner_r  <= pwdata[DIM_W-1:0];
        REG_B_COLS:    b_cols_r <= pwdata[DIM_W-1:0];
        REG_THRESHOLD: thr_r    <= pwdata[THR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_A_ROWS:    prdata = CFG_DATA_W'(a_rows_r);
      REG_INNER:     prdata = CFG_DATA_W'(inner_r);
      REG_B_COLS:    prdata = CFG_DATA_W'(b_cols_r);
      REG_THRESHOLD: prdata = CFG_DATA_W'(thr_r);
    endcase
  end

  // Input side: only idle takes a transfer
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid & ~in_stall;

  assign ld_in_range = (32'(in_data.row) < MAX_DIM) && (32'(in_data.col) < MAX_DIM);
  assign a_we    = in_xfer && (in_data.command == CMD_LOAD_A) && ld_in_range;
  assign b_we    = in_xfer && (in_data.command == CMD_LOAD_B) && ld_in_range;
  assign ld_addr = IDX_W'(32'(in_data.row) * MAX_DIM + 32'(in_data.col));

  // Store read addresses: A[i][k], B[k][j]
  assign a_rd_addr = IDX_W'(32'(i_r) * MAX_DIM + 32'(k_r));
  assign b_rd_addr = IDX_W'(32'(k_r) * MAX_DIM + 32'(j_r));

  // Element stores, registered read
  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[ld_addr] <= in_data.value;
    end
    a_rd_r <= a_mem[a_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[ld_addr] <= in_data.value;
    end
    b_rd_r <= b_mem[b_rd_addr];
  end

  // Shared 32x32 signed multiplier, full 64-bit product
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_r <= $signed(a_rd_r) * $signed(b_rd_r);
    end
  end

  // Scale back and saturating accumulate
  assign term    = prod_r >>> FRAC_BITS;
  assign sum_ext = {acc_r[63], acc_r} + {term[63], term};
  always_comb begin
    if (sum_ext[64] != sum_ext[63]) begin
      acc_sat = sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_sat = sum_ext[63:0];
    end
  end

  // Saturate to 32 bits, then flush small magnitudes
  assign hi_ok   = (&acc_r[63:31]) | ~(|acc_r[63:31]);
  assign res_sat = hi_ok ? acc_r[31:0] :
                   (acc_r[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
  assign res_mag = res_sat[31] ? (33'd0 - {res_sat[31], res_sat}) : {1'b0, res_sat};
  assign res_final = (res_mag < 33'(run_thr_r)) ? 32'sd0 : res_sat;

  // Sequencer
  assign out_free  = ~out_valid_r | ~out_stall;
  assign emit      = (state_r == ST_FIN) && out_free;
  assign last_term = (k_r == inn_r - DIM_W'(1));
  assign last_elem = (i_r == rows_r - DIM_W'(1)) && (j_r == cols_r - DIM_W'(1));

  always_comb begin
    state_nxt = state_r;
    rows_nxt  = rows_r;
    inn_nxt   = inn_r;
    cols_nxt  = cols_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_data.command == CMD_COMPUTE)) begin
          rows_nxt  = clamp_dim(a_rows_r);
          inn_nxt   = clamp_dim(inner_r);
          cols_nxt  = clamp_dim(b_cols_r);
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD:  state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        acc_nxt = acc_sat;
        if (last_term) begin
          state_nxt = ST_FIN;
        end else begin
          k_nxt     = k_r + DIM_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          acc_nxt = '0;
          k_nxt   = '0;
          if (last_elem) begin
            state_nxt = ST_IDLE;
          end else begin
            if (j_r == cols_r - DIM_W'(1)) begin
              j_nxt = '0;
              i_nxt = i_r + DIM_W'(1);
            end else begin
              j_nxt = j_r + DIM_W'(1);
            end
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    priority if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
    end
  end

  // Per-compute dimensions and payload
  always_ff @(posedge clk) begin
    rows_r <= rows_nxt;
    inn_r  <= inn_nxt;
    cols_r <= cols_nxt;
    if (in_xfer && (in_data.command == CMD_COMPUTE)) begin
      run_thr_r <= thr_r;
    end
    if (emit) begin
      out_r.out_row   <= i_r[2:0];
      out_r.out_col   <= j_r[2:0];
      out_r.out_value <= res_final;
      out_r.last      <= last_elem;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[sim/matrix_multiply_engine_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply_engine_unit: loads A and B
// elements, issues products under several dimension and threshold settings.
// Depends on mme_pkg and the engine RTL; needs no files or arguments.
module matrix_multiply_engine_unit_tb;
  import mme_pkg::*;

  localparam int DIM_MAX       = 8;
  localparam int FRAC          = 16;
  localparam int RANDOM_ITEMS  = 200;
  // settling wait that covers the tail of a product
  localparam int SETTLE_CYCLES = 32;
  // largest product has 64 elements; the limit also allows for receiver stalls
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam longint S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
  localparam longint S64_MIN = 64'sh8000000000000000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // Tracks the element stores and registers, predicts every product element
  class matmul_scoreboard;
    logic [31:0]      a_elem [DIM_MAX*DIM_MAX];
    logic [31:0]      b_elem [DIM_MAX*DIM_MAX];
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] inner_reg;
    logic [DIM_W-1:0] cols_reg;
    logic [THR_W-1:0] thr_reg;
    out_item_t        expected_elems [$];
    int               n_errors;
    int               n_checked;
    int               n_products;

    function new();
      rows_reg   = 1;
      inner_reg  = 1;
      cols_reg   = 1;
      thr_reg    = '0;
      n_errors   = 0;
      n_checked  = 0;
      n_products = 0;
    endfunction

    // zero acts as one, anything past the store size as the store size
    static function int unsigned eff_dim(logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > DIM_MAX) return DIM_MAX;
      return 32'(d);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_A_ROWS:    rows_reg  = val[DIM_W-1:0];
        REG_INNER:     inner_reg = val[DIM_W-1:0];
        REG_B_COLS:    cols_reg  = val[DIM_W-1:0];
        REG_THRESHOLD: thr_reg   = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Row-major product: floor-shifted terms, wide sum, 32-bit clamp, flush
    function void form_product();
      int unsigned n_rows, n_inner, n_cols;
      longint      acc, term, total, mag;
      out_item_t   e;
      n_rows  = eff_dim(rows_reg);
      n_inner = eff_dim(inner_reg);
      n_cols  = eff_dim(cols_reg);
      n_products++;
      for (int i = 0; i < n_rows; i++) begin
        for (int j = 0; j < n_cols; j++) begin
          acc = 0;
          for (int k = 0; k < n_inner; k++) begin
            term = longint'($signed(a_elem[i*DIM_MAX+k])) *
                   longint'($signed(b_elem[k*DIM_MAX+j]));
            term  = term >>> FRAC;
            total = acc + term;
            if (term > 0 && total < acc) total = S64_MAX;
            else if (term < 0 && total > acc) total = S64_MIN;
            acc = total;
          end
          if (acc > S32_MAX) acc = S32_MAX;
          else if (acc < S32_MIN) acc = S32_MIN;
          mag = (acc < 0) ? -acc : acc;
          if (mag < longint'(thr_reg)) acc = 0;
          e.out_row   = 3'(i);
          e.out_col   = 3'(j);
          e.out_value = acc[31:0];
          e.last      = (i == n_rows - 1) && (j == n_cols - 1);
          expected_elems.push_back(e);
        end
      end
    endfunction

    function void accept_item(in_item_t it);
      case (it.command)
        CMD_LOAD_A:  a_elem[{it.row, it.col}] = it.value;
        CMD_LOAD_B:  b_elem[{it.row, it.col}] = it.value;
        CMD_COMPUTE: form_product();
        default: ;
      endcase
    endfunction

    function void check_element(out_item_t got);
      out_item_t want;
      if (expected_elems.size() == 0) begin
        $error("unexpected result transfer: row %0d col %0d value %0d last %0d",
               got.out_row, got.out_col, $signed(got.out_value), got.last);
        n_errors++;
        return;
      end
      want = expected_elems.pop_front();
      n_checked++;
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
        n_errors++;
      end
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
        n_errors++;
      end
      if (got.out_value !== want.out_value) begin
        $error("out_value: expected %0d, got %0d (element %0d,%0d)",
               $signed(want.out_value), $signed(got.out_value),
               want.out_row, want.out_col);
        n_errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        n_errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  matmul_scoreboard sb;
  bit               steady;
  logic [63:0]      a_loaded;
  logic [63:0]      b_loaded;
  int               work_items;
  int               n_settings;
  int               cycle_count;

  matrix_multiply_engine_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // Receiver stalls at random outside the steady stretch
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 31);
  end

  // Observe both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.accept_item(in_data);
      if (out_valid && !out_stall) sb.check_element(out_data);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout with %0d result elements outstanding", sb.expected_elems.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic [1:0] cmd, input logic [2:0] row,
                                         input logic [2:0] col, input logic [31:0] val);
    in_item_t it;
    it.command = cmd;
    it.row     = row;
    it.col     = col;
    it.value   = val;
    return it;
  endfunction

  // Mostly small Q16.16 values within +/-8.0, some extremes, some full range
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFFFFFF;
          1:       return 32'h80000000;
          2:       return 32'h00000000;
          default: return 32'hFFFFFFFF;
        endcase
      end
      default: return $urandom_range(0, 32'hFFFFF) - 32'h80000;
    endcase
  endfunction

  function automatic logic [3:0] pick_dim();
    if ($urandom_range(0, 7) != 0) return 4'($urandom_range(1, 3));
    case ($urandom_range(0, 3))
      0:       return 4'd0;
      1:       return 4'd8;
      2:       return 4'($urandom_range(9, 14));
      default: return 4'd15;
    endcase
  endfunction

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(0, 4))
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 64));
      3:       return 16'($urandom_range(0, 16'hFFFF));
      default: return 16'h0000;
    endcase
  endfunction

  // Unused command or a stray load to a random spot
  function automatic in_item_t make_noise();
    if ($urandom_range(0, 1) == 0)
      return make_item(CMD_UNUSED, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                       $urandom);
    return make_item(($urandom_range(0, 1) == 0) ? CMD_LOAD_A : CMD_LOAD_B,
                     3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), pick_value());
  endfunction

  // One input transfer; called and returns at a falling edge
  task automatic send(input in_item_t it);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (it.command == CMD_LOAD_A) a_loaded[{it.row, it.col}] = 1'b1;
    if (it.command == CMD_LOAD_B) b_loaded[{it.row, it.col}] = 1'b1;
    if (it.command != CMD_UNUSED) work_items++;
  endtask

  // APB write: setup then access phase; the caller ends the burst
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  // Hold off until the engine is idle, then reprogram all registers
  task automatic set_dims(input logic [3:0] r, input logic [3:0] k,
                          input logic [3:0] c, input logic [15:0] thr);
    while (sb.expected_elems.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_A_ROWS, 32'(r));
    write_reg(REG_INNER, 32'(k));
    write_reg(REG_B_COLS, 32'(c));
    write_reg(REG_THRESHOLD, 32'(thr));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_settings++;
  endtask

  // Corner cases on 1x1 products: both saturation ends, floor rounding,
  // threshold boundary, zero dimensions, unused command
  task automatic directed_checks();
    send(make_item(CMD_LOAD_A, 0, 0, 32'h7FFFFFFF));
    send(make_item(CMD_LOAD_B, 0, 0, 32'h7FFFFFFF));
    send(make_item(CMD_UNUSED, 7, 7, $urandom));
    send(make_item(CMD_COMPUTE, 0, 0, 0));
    send(make_item(CMD_LOAD_A, 0, 0, 32'h80000000));
    send(make_item(CMD_COMPUTE, 7, 7, 32'hFFFFFFFF));
    send(make_item(CMD_LOAD_B, 0, 0, 32'h80000000));
    send(make_item(CMD_COMPUTE, 0, 0, 0));
    // -1 ulp times 1 ulp floors to -1 ulp
    send(make_item(CMD_LOAD_A, 0, 0, 32'hFFFFFFFF));
    send(make_item(CMD_LOAD_B, 0, 0, 32'h00000001));
    send(make_item(CMD_COMPUTE, 0, 0, 0));
    in_valid <= 1'b0;
    // magnitude equal to the threshold is kept, below it is flushed
    set_dims(1, 1, 1, 16'd1);
    send(make_item(CMD_COMPUTE, 0, 0, 0));
    in_valid <= 1'b0;
    set_dims(1, 1, 1, 16'd2);
    send(make_item(CMD_COMPUTE, 0, 0, 0));
    in_valid <= 1'b0;
    set_dims(0, 0, 0, 16'hFFFF);
    send(make_item(CMD_LOAD_A, 7, 7, 32'h7FFFFFFF));
    send(make_item(CMD_LOAD_B, 7, 7, 32'h80000000));
    send(make_item(CMD_COMPUTE, 0, 0, 0));
    in_valid <= 1'b0;
  endtask

  // Well-formed load-then-compute sequences with some noise mixed in
  task automatic random_products();
    int unsigned first, seq, n_rows, n_inner, n_cols;
    int          idx;
    logic [3:0]  r, k, c;
    bit          reuse;
    in_item_t    loads [$];
    in_item_t    it;
    first = work_items;
    seq   = 0;
    while (work_items < first + RANDOM_ITEMS) begin
      case (seq)
        0: begin r = 4'd15; k = 4'd0; c = 4'd8; end
        1: begin r = 4'd1;  k = 4'd8; c = 4'd1; end
        default: begin r = pick_dim(); k = pick_dim(); c = pick_dim(); end
      endcase
      steady = (seq >= 6 && seq < 12);
      set_dims(r, k, c, pick_threshold());
      n_rows  = matmul_scoreboard::eff_dim(r);
      n_inner = matmul_scoreboard::eff_dim(k);
      n_cols  = matmul_scoreboard::eff_dim(c);
      // reuse keeps earlier contents and fills only missing entries
      reuse = ($urandom_range(0, 3) == 0);
      loads.delete();
      for (int i = 0; i < n_rows; i++)
        for (int m = 0; m < n_inner; m++)
          if (!reuse || !a_loaded[i*DIM_MAX+m])
            loads.push_back(make_item(CMD_LOAD_A, 3'(i), 3'(m), pick_value()));
      for (int m = 0; m < n_inner; m++)
        for (int j = 0; j < n_cols; j++)
          if (!reuse || !b_loaded[m*DIM_MAX+j])
            loads.push_back(make_item(CMD_LOAD_B, 3'(m), 3'(j), pick_value()));
      while (loads.size() != 0) begin
        if ($urandom_range(0, 9) == 0) send(make_noise());
        idx = $urandom_range(0, loads.size() - 1);
        it  = loads[idx];
        loads.delete(idx);
        send(it);
      end
      send(make_item(CMD_COMPUTE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     $urandom));
      if ($urandom_range(0, 3) == 0)
        send(make_item(CMD_COMPUTE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                       $urandom));
      in_valid <= 1'b0;
      seq++;
    end
    steady = 0;
  endtask

  initial begin
    sb          = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    steady      = 1'b0;
    a_loaded    = '0;
    b_loaded    = '0;
    work_items  = 0;
    n_settings  = 0;
    cycle_count = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_checks();
    random_products();
    while (sb.expected_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d load/compute transfers, %0d products, %0d elements checked",
             work_items, sb.n_products, sb.n_checked);
    $display("across %0d register settings, %0d mismatches", n_settings, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
